// ----- rtl/core/modular_field_arith_256_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the modular field arithmetic pipeline
// Shared check forms; clk and arst_n must be in scope where they are used.
// ----------------------------------------------------------------------------
`ifndef MODULAR_FIELD_ARITH_256_DEFINES_SVH
`define MODULAR_FIELD_ARITH_256_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define MFA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define MFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/mfa_pkg.sv -----
// ----------------------------------------------------------------------------
// mfa_pkg
// Widths, operation codes and register indexes of the field arithmetic unit.
// ----------------------------------------------------------------------------
package mfa_pkg;

	localparam int LIMB_W    = 64;
	localparam int FIELD_W   = 256;
	localparam int DIG_W     = 32;
	localparam int NUM_DIG   = FIELD_W / DIG_W;
	localparam int INV_W     = 128;
	localparam int INV_DIG   = INV_W / DIG_W;
	localparam int ROW_W     = FIELD_W + DIG_W;
	localparam int NUM_STG   = 14;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOD0   = 3'd0,
		CFG_MOD1   = 3'd1,
		CFG_MOD2   = 3'd2,
		CFG_MOD3   = 3'd3,
		CFG_NINV_L = 3'd4,
		CFG_NINV_H = 3'd5
	} cfg_idx_t;

	// Operation and add/subtract result riding alongside the multiplier
	typedef struct packed {
		logic [1:0]         op;
		logic [FIELD_W-1:0] ras;
	} side_t;

endpackage

// ----- rtl/core/modular_field_arith_256.sv -----
// ----------------------------------------------------------------------------
// modular_field_arith_256
// 256-bit modular add, subtract and Montgomery multiply, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries operation, a_limb0..3 and
//   b_limb0..3. Output channel (out_valid/out_ready) carries r_limb0..3.
//   Load modulus_limb0..3 and -m^-1 mod 2^128 through cfg_we/cfg_index/
//   cfg_data while no word is in flight; indexes above 5 are ignored.
//   One word is accepted every cycle while in_ready is high: 32x32 partial
//   products are registered, then summed in row and column stages, for a*b,
//   both 128-bit reduction rounds and the final conditional subtraction.
//   When the receiver stalls, words pile up stage by stage; in_ready drops
//   only once all 14 stages hold a word. Nothing is lost or repeated.
//   Reset clears the modulus, the inverse and all stage valid bits.
//   Operation 3 returns zero.
// ----------------------------------------------------------------------------
`include "modular_field_arith_256_defines.svh"

module modular_field_arith_256
	import mfa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMB_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           operation,
	input  logic [LIMB_W-1:0]    a_limb0,
	input  logic [LIMB_W-1:0]    a_limb1,
	input  logic [LIMB_W-1:0]    a_limb2,
	input  logic [LIMB_W-1:0]    a_limb3,
	input  logic [LIMB_W-1:0]    b_limb0,
	input  logic [LIMB_W-1:0]    b_limb1,
	input  logic [LIMB_W-1:0]    b_limb2,
	input  logic [LIMB_W-1:0]    b_limb3,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [LIMB_W-1:0]    r_limb0,
	output logic [LIMB_W-1:0]    r_limb1,
	output logic [LIMB_W-1:0]    r_limb2,
	output logic [LIMB_W-1:0]    r_limb3
);

	logic [FIELD_W-1:0] mod_q;
	logic [INV_W-1:0]   ninv_q;

	logic [FIELD_W-1:0] a_in, b_in;
	logic [NUM_STG+1:1] en;
	logic [NUM_STG:1]   vld_q;

	// stage registers
	logic [2*DIG_W-1:0]   pp_s1 [NUM_DIG][NUM_DIG];
	logic [1:0]           op_s1;
	logic [FIELD_W:0]     x_s1;
	side_t                side_q [2:13];
	logic [ROW_W-1:0]     row_s2 [NUM_DIG];
	logic [2*FIELD_W-1:0] t_s3, t_s4, t_s5, t_s6, t_s7;
	logic [2*DIG_W-1:0]   pp_s4 [INV_DIG][INV_DIG];
	logic [INV_W-1:0]     k0_s5;
	logic [2*DIG_W-1:0]   pp_s6 [INV_DIG][NUM_DIG];
	logic [ROW_W-1:0]     row_s7 [INV_DIG];
	logic [3*INV_W-1:0]   t2_s8, t2_s9, t2_s10, t2_s11, t2_s12;
	logic [2*DIG_W-1:0]   pp_s9 [INV_DIG][INV_DIG];
	logic [INV_W-1:0]     k1_s10;
	logic [2*DIG_W-1:0]   pp_s11 [INV_DIG][NUM_DIG];
	logic [ROW_W-1:0]     row_s12 [INV_DIG];
	logic [FIELD_W:0]     res_s13;
	logic [FIELD_W-1:0]   r_s14;

	// combinational stage results
	logic [FIELD_W:0]     x_d;
	logic [FIELD_W-1:0]   ras_d;
	logic [ROW_W-1:0]     row2_d [NUM_DIG];
	logic [2*FIELD_W-1:0] t_d;
	logic [INV_W-1:0]     k0_d, k1_d;
	logic [ROW_W-1:0]     row7_d [INV_DIG];
	logic [2*FIELD_W-1:0] p_d;
	logic [ROW_W-1:0]     row12_d [INV_DIG];
	logic [3*INV_W:0]     u_d;
	logic [FIELD_W-1:0]   r_d;

	assign a_in = {a_limb3, a_limb2, a_limb1, a_limb0};
	assign b_in = {b_limb3, b_limb2, b_limb1, b_limb0};

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= '0;
			ninv_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MOD0:   mod_q[0*LIMB_W +: LIMB_W] <= cfg_data;
				CFG_MOD1:   mod_q[1*LIMB_W +: LIMB_W] <= cfg_data;
				CFG_MOD2:   mod_q[2*LIMB_W +: LIMB_W] <= cfg_data;
				CFG_MOD3:   mod_q[3*LIMB_W +: LIMB_W] <= cfg_data;
				CFG_NINV_L: ninv_q[0 +: LIMB_W] <= cfg_data;
				CFG_NINV_H: ninv_q[LIMB_W +: LIMB_W] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		en[NUM_STG+1] = out_ready;
		for (int k = NUM_STG; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[NUM_STG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= in_valid;
			for (int k = 2; k <= NUM_STG; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// Stage 1 add/subtract: raw sum or difference with carry/borrow
	always_comb begin
		if (operation == OP_ADD)
			x_d = {1'b0, a_in} + {1'b0, b_in};
		else
			x_d = {1'b0, a_in} - {1'b0, b_in};
	end

	// Stage 2 add/subtract: reduce once by the modulus
	always_comb begin
		logic [FIELD_W+1:0] y;
		logic [FIELD_W:0]   z;
		y = {1'b0, x_s1} - {2'b0, mod_q};
		z = x_s1 + {1'b0, mod_q};
		ras_d = '0;
		if (op_s1 == OP_ADD)
			ras_d = y[FIELD_W+1] ? x_s1[FIELD_W-1:0] : y[FIELD_W-1:0];
		else if (op_s1 == OP_SUB)
			ras_d = x_s1[FIELD_W] ? z[FIELD_W-1:0] : x_s1[FIELD_W-1:0];
	end

	// Row sums of the a*b partial products
	always_comb begin
		logic [ROW_W-1:0] acc;
		for (int i = 0; i < NUM_DIG; i++) begin
			acc = '0;
			for (int j = 0; j < NUM_DIG; j++)
				acc = acc + (ROW_W'(pp_s1[i][j]) << (DIG_W * j));
			row2_d[i] = acc;
		end
	end

	// Full product t = a*b
	always_comb begin
		logic [2*FIELD_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < NUM_DIG; i++)
			acc = acc + ((2*FIELD_W)'(row_s2[i]) << (DIG_W * i));
		t_d = acc;
	end

	// First quotient k0 = inv * t mod 2^128
	always_comb begin
		logic [INV_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < INV_DIG; i++)
			for (int j = 0; j < INV_DIG; j++)
				if (i + j < INV_DIG)
					acc = acc + INV_W'(({64'b0, pp_s4[i][j]}) << (DIG_W * (i + j)));
		k0_d = acc;
	end

	// Row sums of k0*m
	always_comb begin
		logic [ROW_W-1:0] acc;
		for (int i = 0; i < INV_DIG; i++) begin
			acc = '0;
			for (int j = 0; j < NUM_DIG; j++)
				acc = acc + (ROW_W'(pp_s6[i][j]) << (DIG_W * j));
			row7_d[i] = acc;
		end
	end

	// First round: p = k0*m + t mod 2^512
	always_comb begin
		logic [2*FIELD_W-1:0] acc;
		acc = t_s7;
		for (int i = 0; i < INV_DIG; i++)
			acc = acc + ((2*FIELD_W)'(row_s7[i]) << (DIG_W * i));
		p_d = acc;
	end

	// Second quotient k1 = inv * t2 mod 2^128
	always_comb begin
		logic [INV_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < INV_DIG; i++)
			for (int j = 0; j < INV_DIG; j++)
				if (i + j < INV_DIG)
					acc = acc + INV_W'(({64'b0, pp_s9[i][j]}) << (DIG_W * (i + j)));
		k1_d = acc;
	end

	// Row sums of k1*m
	always_comb begin
		logic [ROW_W-1:0] acc;
		for (int i = 0; i < INV_DIG; i++) begin
			acc = '0;
			for (int j = 0; j < NUM_DIG; j++)
				acc = acc + (ROW_W'(pp_s11[i][j]) << (DIG_W * j));
			row12_d[i] = acc;
		end
	end

	// Second round: u = k1*m + t2
	always_comb begin
		logic [3*INV_W:0] acc;
		acc = {1'b0, t2_s12};
		for (int i = 0; i < INV_DIG; i++)
			acc = acc + ((3*INV_W+1)'(row_s12[i]) << (DIG_W * i));
		u_d = acc;
	end

	// Final conditional subtraction and result select
	always_comb begin
		logic [FIELD_W+1:0] y;
		logic [FIELD_W-1:0] mr;
		y  = {1'b0, res_s13} - {2'b0, mod_q};
		mr = y[FIELD_W+1] ? res_s13[FIELD_W-1:0] : y[FIELD_W-1:0];
		case (side_q[13].op)
			OP_ADD:  r_d = side_q[13].ras;
			OP_SUB:  r_d = side_q[13].ras;
			OP_MUL:  r_d = mr;
			default: r_d = '0;
		endcase
	end

	// Pipeline payload registers
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < NUM_DIG; i++)
				for (int j = 0; j < NUM_DIG; j++)
					pp_s1[i][j] <= a_in[DIG_W*i +: DIG_W] * b_in[DIG_W*j +: DIG_W];
			op_s1 <= operation;
			x_s1  <= x_d;
		end
		if (en[2]) begin
			row_s2       <= row2_d;
			side_q[2].op  <= op_s1;
			side_q[2].ras <= ras_d;
		end
		for (int k = 3; k <= 13; k++)
			if (en[k])
				side_q[k] <= side_q[k-1];
		if (en[3])
			t_s3 <= t_d;
		if (en[4]) begin
			for (int i = 0; i < INV_DIG; i++)
				for (int j = 0; j < INV_DIG; j++)
					pp_s4[i][j] <= ninv_q[DIG_W*i +: DIG_W] * t_s3[DIG_W*j +: DIG_W];
			t_s4 <= t_s3;
		end
		if (en[5]) begin
			k0_s5 <= k0_d;
			t_s5  <= t_s4;
		end
		if (en[6]) begin
			for (int i = 0; i < INV_DIG; i++)
				for (int j = 0; j < NUM_DIG; j++)
					pp_s6[i][j] <= k0_s5[DIG_W*i +: DIG_W] * mod_q[DIG_W*j +: DIG_W];
			t_s6 <= t_s5;
		end
		if (en[7]) begin
			row_s7 <= row7_d;
			t_s7   <= t_s6;
		end
		if (en[8])
			t2_s8 <= p_d[2*FIELD_W-1:INV_W];
		if (en[9]) begin
			for (int i = 0; i < INV_DIG; i++)
				for (int j = 0; j < INV_DIG; j++)
					pp_s9[i][j] <= ninv_q[DIG_W*i +: DIG_W] * t2_s8[DIG_W*j +: DIG_W];
			t2_s9 <= t2_s8;
		end
		if (en[10]) begin
			k1_s10 <= k1_d;
			t2_s10 <= t2_s9;
		end
		if (en[11]) begin
			for (int i = 0; i < INV_DIG; i++)
				for (int j = 0; j < NUM_DIG; j++)
					pp_s11[i][j] <= k1_s10[DIG_W*i +: DIG_W] * mod_q[DIG_W*j +: DIG_W];
			t2_s11 <= t2_s10;
		end
		if (en[12]) begin
			row_s12 <= row12_d;
			t2_s12  <= t2_s11;
		end
		if (en[13])
			res_s13 <= u_d[3*INV_W:INV_W];
		if (en[14])
			r_s14 <= r_d;
	end

	assign r_limb0 = r_s14[0*LIMB_W +: LIMB_W];
	assign r_limb1 = r_s14[1*LIMB_W +: LIMB_W];
	assign r_limb2 = r_s14[2*LIMB_W +: LIMB_W];
	assign r_limb3 = r_s14[3*LIMB_W +: LIMB_W];

	// Checks: back-pressure only when every stage is full, stalled words stay, and the output refills from stage 13
	`MFA_ASSERT_NOW(a_full_stall, !in_ready, &vld_q, "in_ready low with an empty stage")
	`MFA_ASSERT_NEXT(a_mid_hold, vld_q[7] && !en[7], vld_q[7], "stalled word lost in stage 7")
	`MFA_ASSERT_NEXT(a_out_refill, out_valid && out_ready && vld_q[13], out_valid, "no refill")

endmodule

// ----- dv/tb_modular_field_arith_256.sv -----
// ----------------------------------------------------------------------------
// tb_modular_field_arith_256
// Drives add, subtract and Montgomery multiply words through the field
// arithmetic pipeline under several modulus settings and flow-control phases.
// Each result word is checked against an in-bench big-integer predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_modular_field_arith_256;
	import mfa_pkg::*;

	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
	localparam logic [1:0]           OP_NONE      = 2'd3;
	localparam int                   NUM_PHASES   = 8;
	localparam int                   RAND_PER_PH  = 204;

	typedef struct {
		logic [1:0]         op;
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
	} field_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LIMB_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           operation = OP_ADD;
	logic [LIMB_W-1:0]    a_limb0 = '0, a_limb1 = '0, a_limb2 = '0, a_limb3 = '0;
	logic [LIMB_W-1:0]    b_limb0 = '0, b_limb1 = '0, b_limb2 = '0, b_limb3 = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [LIMB_W-1:0]    r_limb0, r_limb1, r_limb2, r_limb3;

	// predictor copy of the registers
	logic [FIELD_W-1:0]   field_mod = '0;
	logic [INV_W-1:0]     neg_inv = '0;

	field_word_t          pending_words[$];
	logic [FIELD_W-1:0]   expected_sums[$];
	int                   send_idle_pct = 0;
	int                   recv_stall_pct = 0;
	int                   mismatches = 0;
	int                   results_seen = 0;
	int                   op_count[4] = '{0, 0, 0, 0};

	modular_field_arith_256 i_dut (.*);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic logic [FIELD_W-1:0] field_result(field_word_t w);
		logic [FIELD_W:0]     s;
		logic [511:0]         t;
		logic [127:0]         k0, k1;
		logic [511:0]         p;
		logic [383:0]         t2;
		logic [385:0]         u;
		logic [257:0]         res;
		if (w.op == OP_ADD) begin
			s = {1'b0, w.a} + {1'b0, w.b};
			if (s >= {1'b0, field_mod})
				s = s - {1'b0, field_mod};
			return s[FIELD_W-1:0];
		end else if (w.op == OP_SUB) begin
			if (w.a < w.b)
				return w.a + field_mod - w.b;
			return w.a - w.b;
		end else if (w.op == OP_MUL) begin
			t = {256'b0, w.a} * {256'b0, w.b};
			k0 = neg_inv * t[127:0];
			p = {384'b0, k0} * {256'b0, field_mod} + t;
			t2 = p[511:128];
			k1 = neg_inv * t2[127:0];
			u = {258'b0, k1} * {130'b0, field_mod} + {2'b0, t2};
			res = u[385:128];
			if (res >= {2'b0, field_mod})
				res = res - {2'b0, field_mod};
			return res[FIELD_W-1:0];
		end
		return '0;
	endfunction

	// -m^-1 mod 2^128 by Newton iteration, m odd
	function automatic logic [INV_W-1:0] mont_neg_inverse(logic [FIELD_W-1:0] m);
		logic [INV_W-1:0] x;
		x = m[INV_W-1:0];
		repeat (7)
			x = x * (128'd2 - m[INV_W-1:0] * x);
		return -x;
	endfunction

	function automatic logic [FIELD_W-1:0] rand_wide();
		logic [FIELD_W-1:0] v;
		for (int i = 0; i < 8; i++)
			v[i*32 +: 32] = $urandom;
		return v;
	endfunction

	// operand: mostly reduced, sometimes an extreme or unreduced
	function automatic logic [FIELD_W-1:0] rand_operand();
		int pick;
		pick = $urandom_range(99);
		if (pick < 4)
			return '0;
		if (pick < 8)
			return field_mod - 1;
		if (pick < 11)
			return '1;
		if (pick < 25 || field_mod == '0)
			return rand_wide();
		return rand_wide() % field_mod;
	endfunction

	function automatic logic [1:0] rand_op();
		return ($urandom_range(15) == 0) ? OP_NONE : 2'($urandom_range(2));
	endfunction

	task automatic report_mismatch(string what, logic [LIMB_W-1:0] got,
		logic [LIMB_W-1:0] want);
		$display("MISMATCH %s at %0t: got %h want %h", what, $realtime, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// driver: hold each word until accepted
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		field_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				w = pending_words.pop_front();
				in_valid  <= 1'b1;
				operation <= w.op;
				{a_limb3, a_limb2, a_limb1, a_limb0} <= w.a;
				{b_limb3, b_limb2, b_limb1, b_limb0} <= w.b;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// monitor: predict on input accept, check on output accept
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		field_word_t        w;
		logic [FIELD_W-1:0] want;
		if (arst_n && in_valid && in_ready) begin
			w.op = operation;
			w.a = {a_limb3, a_limb2, a_limb1, a_limb0};
			w.b = {b_limb3, b_limb2, b_limb1, b_limb0};
			expected_sums.push_back(field_result(w));
			op_count[w.op]++;
		end
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_sums.size() == 0) begin
				report_mismatch("unexpected word", r_limb0, '0);
			end else begin
				want = expected_sums.pop_front();
				if (r_limb0 !== want[63:0])
					report_mismatch("r_limb0", r_limb0, want[63:0]);
				if (r_limb1 !== want[127:64])
					report_mismatch("r_limb1", r_limb1, want[127:64]);
				if (r_limb2 !== want[191:128])
					report_mismatch("r_limb2", r_limb2, want[191:128]);
				if (r_limb3 !== want[255:192])
					report_mismatch("r_limb3", r_limb3, want[255:192]);
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	// sample at the falling edge, once the driver and monitor have settled
	task automatic wait_drained();
		@(negedge clk);
		while (pending_words.size() > 0 || in_valid || expected_sums.size() > 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMB_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_MOD0:   field_mod[63:0]    = data;
			CFG_MOD1:   field_mod[127:64]  = data;
			CFG_MOD2:   field_mod[191:128] = data;
			CFG_MOD3:   field_mod[255:192] = data;
			CFG_NINV_L: neg_inv[63:0]      = data;
			CFG_NINV_H: neg_inv[127:64]    = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_field(logic [FIELD_W-1:0] m, logic [INV_W-1:0] inv);
		write_reg(CFG_MOD0, m[63:0]);
		write_reg(CFG_MOD1, m[127:64]);
		write_reg(CFG_MOD2, m[191:128]);
		write_reg(CFG_MOD3, m[255:192]);
		write_reg(CFG_NINV_L, inv[63:0]);
		write_reg(CFG_NINV_H, inv[127:64]);
		// spare indexes must not disturb anything
		write_reg(IDX_SPARE_LO, LIMB_W'($urandom));
		write_reg(IDX_SPARE_HI, {$urandom, $urandom});
	endtask

	task automatic push_word(logic [1:0] op, logic [FIELD_W-1:0] a,
		logic [FIELD_W-1:0] b);
		field_word_t w;
		w.op = op;
		w.a = a;
		w.b = b;
		pending_words.push_back(w);
	endtask

	initial begin
		logic [FIELD_W-1:0] m;
		logic [FIELD_W-1:0] mm1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			repeat (20) @(posedge clk);
			m = rand_wide();
			case (ph)
				0, 5: begin
					m[255] = 1'b1;
					m[0] = 1'b1;
					load_field(m, mont_neg_inverse(m));
				end
				1: load_field('1, mont_neg_inverse('1));
				2: begin
					m = {192'b0, m[63:0]} | 256'd1;
					load_field(m, mont_neg_inverse(m));
				end
				3: load_field('0, '0);
				4: begin
					m[0] = 1'b0;
					load_field(m, INV_W'(rand_wide()));
				end
				6: load_field(256'd1, '1);
				default: begin
					m[0] = 1'b1;
					load_field(m, mont_neg_inverse(m));
				end
			endcase
			send_idle_pct  = (ph % 4 == 1) ? 50 : (ph % 4 == 3) ? 19 : 0;
			recv_stall_pct = (ph % 4 == 2) ? 50 : (ph % 4 == 3) ? 19 : 0;

			if (ph == 0) begin
				// extremes of every operation, wrap and reduce boundaries
				mm1 = field_mod - 1;
				push_word(OP_ADD, '0, '0);
				push_word(OP_ADD, mm1, mm1);
				push_word(OP_ADD, mm1, 256'd1);
				push_word(OP_ADD, '1, '1);
				push_word(OP_SUB, '0, mm1);
				push_word(OP_SUB, mm1, mm1);
				push_word(OP_SUB, mm1, '0);
				push_word(OP_SUB, '0, '1);
				push_word(OP_SUB, '1, '0);
				push_word(OP_MUL, 256'd1, 256'd1);
				push_word(OP_MUL, mm1, mm1);
				push_word(OP_MUL, '0, mm1);
				push_word(OP_MUL, '1, '1);
				push_word(OP_MUL, mm1, 256'd1);
				push_word(OP_NONE, '1, '1);
				push_word(OP_NONE, '0, '0);
				// hold off until the pipeline empties, then refill
				wait_drained();
			end

			for (int i = 0; i < RAND_PER_PH; i++) begin
				m = rand_operand();
				case ($urandom_range(3))
					0: push_word(OP_MUL, m, m);
					default: push_word(rand_op(), m, rand_operand());
				endcase
			end
		end

		wait_drained();
		repeat (30) @(posedge clk);
		$display("Ran %0d words over %0d modulus settings and four flow-control modes.",
			results_seen, NUM_PHASES);
		$display("Mix: %0d add, %0d subtract, %0d multiply, %0d unused opcode.",
			op_count[0], op_count[1], op_count[2], op_count[3]);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("TIMEOUT at %0t", $realtime);
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mfa_pkg.sv
rtl/core/modular_field_arith_256.sv
dv/tb_modular_field_arith_256.sv
